FILE: design/ple_pkg.sv
// Package for the positional list engine: sizes, operation and status codes,
// sequencer states and the memory command bundle.
// No dependencies.
package ple_pkg;

	localparam int DEPTH = 32;
	localparam int IDX_W = $clog2(DEPTH);
	localparam int LEN_W = 6;
	localparam int POS_W = 7;
	localparam int VAL_W = 32;
	localparam int OP_W  = 3;
	localparam int ST_W  = 2;

	typedef enum logic [OP_W-1:0] {
		OP_INS_FIRST = 3'd0,
		OP_INS_LAST  = 3'd1,
		OP_INS_AT    = 3'd2,
		OP_DEL_FIRST = 3'd3,
		OP_DEL_LAST  = 3'd4,
		OP_DEL_AT    = 3'd5,
		OP_DUMP      = 3'd6
	} op_t;

	typedef enum logic [ST_W-1:0] {
		STAT_OK     = 2'd0,
		STAT_FULL   = 2'd1,
		STAT_BADPOS = 2'd2,
		STAT_EMPTY  = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_MOVE,
		S_PUT,
		S_REPLY,
		S_DUMP
	} state_t;

	typedef struct packed {
		logic                    re;
		logic [IDX_W-1:0]        raddr;
		logic                    we;
		logic [IDX_W-1:0]        waddr;
		logic signed [VAL_W-1:0] wdata;
	} ram_cmd_t;

endpackage

FILE: design/ple_if.sv
// Handshake interfaces for the positional list engine: request and result channels.
// Depends on ple_pkg.
interface ple_req_if import ple_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic [OP_W-1:0]         op;
	logic signed [VAL_W-1:0] value;
	logic [POS_W-1:0]        position;

	modport source (output valid, output op, output value, output position, input ready);
	modport sink (input valid, input op, input value, input position, output ready);
endinterface

interface ple_rsp_if import ple_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic signed [VAL_W-1:0] value_out;
	logic [LEN_W-1:0]        length;
	logic [ST_W-1:0]         status;
	logic                    last;

	modport source (output valid, output value_out, output length, output status,
		output last, input ready);
	modport sink (input valid, input value_out, input length, input status,
		input last, output ready);
endinterface

FILE: design/ple_ram.sv
// Element store: one write port, one read port, read data registered.
// Depends on ple_pkg.
module ple_ram import ple_pkg::*; (
	input  logic                    clk,
	input  ram_cmd_t                cmd,
	output logic signed [VAL_W-1:0] rdata
);

	logic signed [VAL_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (cmd.we) begin
			mem[cmd.waddr] <= cmd.wdata;
		end
		if (cmd.re) begin
			rdata <= mem[cmd.raddr];
		end
	end

endmodule

FILE: design/positional_list_engine.sv
// Positional list engine: an ordered list of signed 32-bit values held in a
// single-port-pair memory, with insert, delete and dump requests.
// Depends on ple_pkg, ple_if and ple_ram.

// The list lives packed in a 32-entry memory (one read and one write port, read
// data registered); slot 0 is the front. One request is handled at a time.
// An insert or delete shifts every element behind the affected slot by one place,
// one element per cycle: the read of the next element overlaps the write-back of
// the previous one. The more elements lie behind the slot, the longer the shift,
// so front inserts and deletes of long lists are the slowest. After the shift an
// insert writes its own value into the slot. A rejected request (full, bad position,
// empty) skips the memory and goes straight to the reply state. A dump reads each
// element from memory and loads it into the output register before the next read,
// which also waits for that register to be free; the request side stays closed until
// the last one is loaded. Results wait in an output register, so a stalled consumer
// only holds the engine at the point where it needs to load another result.
module positional_list_engine import ple_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	ple_req_if.sink   req,
	ple_rsp_if.source rsp
);

	state_t state_q, state_d;

	logic [LEN_W-1:0]        count_q;
	logic signed [VAL_W-1:0] value_q;
	logic [IDX_W-1:0]        idx_q;
	logic [IDX_W-1:0]        ptr_q;
	logic [LEN_W-1:0]        left_q;
	logic                    ins_q;
	status_t                 status_q;

	logic                    rd_pend_s1;
	logic                    last_s1;
	logic [IDX_W-1:0]        waddr_s1;

	logic                    out_valid_q;
	logic signed [VAL_W-1:0] out_value_q;
	logic [LEN_W-1:0]        out_len_q;
	logic [ST_W-1:0]         out_status_q;
	logic                    out_last_q;

	ram_cmd_t                ram_cmd;
	logic signed [VAL_W-1:0] ram_rdata;

	// decode of the incoming request
	status_t          dec_status;
	logic             dec_ins;
	logic             dec_del;
	logic             dec_dump;
	logic [IDX_W-1:0] dec_idx;
	logic [LEN_W-1:0] dec_moves;
	logic [IDX_W-1:0] dec_src;
	logic [LEN_W-1:0] dec_count;
	logic [POS_W-1:0] cnt_ext;
	logic [POS_W-1:0] pos_m1;
	logic [LEN_W-1:0] idx_ext;

	// sequencer outputs
	logic             accept;
	logic             out_free;
	logic             out_load;
	logic signed [VAL_W-1:0] out_value;
	status_t          out_status;
	logic             out_last;
	logic             step;

	assign accept   = req.valid && req.ready;
	assign out_free = !out_valid_q || rsp.ready;
	assign cnt_ext  = {{(POS_W-LEN_W){1'b0}}, count_q};
	assign pos_m1   = req.position - POS_W'(1);

	always_comb begin
		dec_status = STAT_OK;
		dec_ins    = 1'b0;
		dec_del    = 1'b0;
		dec_dump   = 1'b0;
		dec_idx    = '0;
		dec_count  = count_q;
		case (req.op)
			OP_INS_FIRST, OP_INS_LAST, OP_INS_AT: begin
				if (count_q == LEN_W'(DEPTH)) begin
					dec_status = STAT_FULL;
				end else if (req.op == OP_INS_FIRST) begin
					dec_ins = 1'b1;
				end else if (req.op == OP_INS_LAST) begin
					dec_ins = 1'b1;
					dec_idx = count_q[IDX_W-1:0];
				end else if (req.position == '0 || req.position > cnt_ext + POS_W'(1)) begin
					dec_status = STAT_BADPOS;
				end else begin
					dec_ins = 1'b1;
					dec_idx = pos_m1[IDX_W-1:0];
				end
				if (dec_ins) begin
					dec_count = count_q + LEN_W'(1);
				end
			end
			OP_DEL_FIRST, OP_DEL_LAST, OP_DEL_AT: begin
				if (count_q == '0) begin
					dec_status = STAT_EMPTY;
				end else if (req.op == OP_DEL_FIRST) begin
					dec_del = 1'b1;
				end else if (req.op == OP_DEL_LAST) begin
					dec_del = 1'b1;
					dec_idx = IDX_W'(count_q - LEN_W'(1));
				end else if (req.position == '0 || req.position > cnt_ext) begin
					dec_status = STAT_BADPOS;
				end else begin
					dec_del = 1'b1;
					dec_idx = pos_m1[IDX_W-1:0];
				end
				if (dec_del) begin
					dec_count = count_q - LEN_W'(1);
				end
			end
			OP_DUMP: begin
				if (count_q == '0) begin
					dec_status = STAT_EMPTY;
				end else begin
					dec_dump = 1'b1;
				end
			end
			default: begin
				dec_status = STAT_OK;
			end
		endcase
	end

	assign idx_ext = {{(LEN_W-IDX_W){1'b0}}, dec_idx};

	// insert: copy from the back towards the slot; delete: pull the tail forwards
	always_comb begin
		if (dec_ins) begin
			dec_moves = count_q - idx_ext;
			dec_src   = IDX_W'(count_q - LEN_W'(1));
		end else if (dec_del) begin
			dec_moves = count_q - LEN_W'(1) - idx_ext;
			dec_src   = dec_idx + IDX_W'(1);
		end else begin
			dec_moves = count_q;
			dec_src   = '0;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (dec_dump) begin
						state_d = S_DUMP;
					end else if (dec_ins || dec_del) begin
						state_d = S_MOVE;
					end else begin
						state_d = S_REPLY;
					end
				end
			end
			S_MOVE: begin
				if (left_q == '0 && !rd_pend_s1) begin
					state_d = ins_q ? S_PUT : S_REPLY;
				end
			end
			S_PUT: begin
				state_d = S_REPLY;
			end
			S_REPLY: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			S_DUMP: begin
				if (left_q == '0 && !rd_pend_s1) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// sequencer outputs: memory commands and result loading
	always_comb begin
		req.ready     = 1'b0;
		step          = 1'b0;
		ram_cmd.re    = 1'b0;
		ram_cmd.raddr = ptr_q;
		ram_cmd.we    = 1'b0;
		ram_cmd.waddr = waddr_s1;
		ram_cmd.wdata = ram_rdata;
		out_load      = 1'b0;
		out_value     = '0;
		out_status    = status_q;
		out_last      = 1'b1;
		case (state_q)
			S_IDLE: begin
				req.ready = 1'b1;
			end
			S_MOVE: begin
				step       = (left_q != '0);
				ram_cmd.re = step;
				ram_cmd.we = rd_pend_s1;
			end
			S_PUT: begin
				ram_cmd.we    = 1'b1;
				ram_cmd.waddr = idx_q;
				ram_cmd.wdata = value_q;
			end
			S_REPLY: begin
				out_load = out_free;
			end
			S_DUMP: begin
				step       = (left_q != '0) && !rd_pend_s1 && out_free;
				ram_cmd.re = step;
				out_load   = rd_pend_s1;
				out_value  = ram_rdata;
				out_status = STAT_OK;
				out_last   = last_s1;
			end
			default: begin
				req.ready = 1'b0;
			end
		endcase
	end

	ple_ram u_ram (
		.clk   (clk),
		.cmd   (ram_cmd),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			left_q      <= '0;
			rd_pend_s1  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			rd_pend_s1 <= step;
			if (accept) begin
				count_q <= dec_count;
				left_q  <= (dec_ins || dec_del || dec_dump) ? dec_moves : '0;
			end else if (step) begin
				left_q <= left_q - LEN_W'(1);
			end
			// hold the result until taken, replace it as soon as it goes
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			value_q  <= req.value;
			idx_q    <= dec_idx;
			ins_q    <= dec_ins;
			status_q <= dec_status;
			ptr_q    <= dec_src;
		end else if (step) begin
			// advance the source pointer: down for inserts, up for deletes and dumps
			ptr_q <= ins_q ? ptr_q - IDX_W'(1) : ptr_q + IDX_W'(1);
		end
		if (step) begin
			waddr_s1 <= ins_q ? ptr_q + IDX_W'(1) : ptr_q - IDX_W'(1);
			last_s1  <= (left_q == LEN_W'(1));
		end
		if (out_load) begin
			out_value_q  <= out_value;
			out_len_q    <= count_q;
			out_status_q <= out_status;
			out_last_q   <= out_last;
		end
	end

	assign rsp.valid     = out_valid_q;
	assign rsp.value_out = out_value_q;
	assign rsp.length    = out_len_q;
	assign rsp.status    = out_status_q;
	assign rsp.last      = out_last_q;

endmodule

FILE: design/ple_checker.sv
// Port-level checks for the positional list engine, bound to the top level.
// Depends on ple_pkg.
module ple_checker import ple_pkg::*; (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    req_ready,
	input logic                    rsp_valid,
	input logic                    rsp_ready,
	input logic signed [VAL_W-1:0] rsp_value_out,
	input logic [LEN_W-1:0]        rsp_length,
	input logic [ST_W-1:0]         rsp_status,
	input logic                    rsp_last
);

	// a stalled result holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_value_out)
			&& $stable(rsp_length) && $stable(rsp_status) && $stable(rsp_last))
		else $error("result changed while stalled");

	a_len_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_length <= LEN_W'(DEPTH))
		else $error("length beyond depth");

	a_empty_len: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status == STAT_EMPTY |-> rsp_length == '0 && rsp_value_out == '0)
		else $error("empty status with elements held");

	a_full_len: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status == STAT_FULL |-> rsp_length == LEN_W'(DEPTH))
		else $error("full status below depth");

	// a dump in progress keeps the request side closed
	a_dump_closed: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_last |-> !req_ready && rsp_status == STAT_OK)
		else $error("request accepted during dump");

endmodule

bind positional_list_engine ple_checker u_ple_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.req_ready     (req.ready),
	.rsp_valid     (rsp.valid),
	.rsp_ready     (rsp.ready),
	.rsp_value_out (rsp.value_out),
	.rsp_length    (rsp.length),
	.rsp_status    (rsp.status),
	.rsp_last      (rsp.last)
);

FILE: tb/sv/ple_list_checker.sv
// Scoreboard for the positional list engine: watches the request and result
// channels, keeps its own copy of the list and compares every result.
// Depends on ple_pkg and ple_if.
module ple_list_checker import ple_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	ple_req_if   req,
	ple_rsp_if   rsp,
	output int   fail_count,
	output int   results_due
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic signed [VAL_W-1:0] value_out;
		logic [LEN_W-1:0]        length;
		status_t                 status;
		logic                    last;
	} list_result_t;

	logic signed [VAL_W-1:0] held_values[$];
	list_result_t            awaited_results[$];
	int                      mismatches = 0;

	function automatic void await_result(logic signed [VAL_W-1:0] v, int n, status_t st,
		logic fin);
		list_result_t r;
		r.value_out = v;
		r.length    = LEN_W'(n);
		r.status    = st;
		r.last      = fin;
		awaited_results.push_back(r);
	endfunction

	// Update the list copy for one request and queue the results it causes.
	function automatic void apply_request(logic [OP_W-1:0] code,
		logic signed [VAL_W-1:0] val, logic [POS_W-1:0] pos);
		int      n;
		status_t st;
		n  = held_values.size();
		st = STAT_OK;
		case (code)
			OP_INS_FIRST, OP_INS_LAST, OP_INS_AT: begin
				// full is checked before the position
				if (n >= DEPTH)
					st = STAT_FULL;
				else if (code == OP_INS_FIRST)
					held_values.push_front(val);
				else if (code == OP_INS_LAST)
					held_values.push_back(val);
				else if (pos == 0 || int'(pos) > n + 1)
					st = STAT_BADPOS;
				else
					held_values.insert(int'(pos) - 1, val);
			end
			OP_DEL_FIRST, OP_DEL_LAST, OP_DEL_AT: begin
				if (n == 0)
					st = STAT_EMPTY;
				else if (code == OP_DEL_FIRST)
					void'(held_values.pop_front());
				else if (code == OP_DEL_LAST)
					void'(held_values.pop_back());
				else if (pos == 0 || int'(pos) > n)
					st = STAT_BADPOS;
				else
					held_values.delete(int'(pos) - 1);
			end
			OP_DUMP: begin
				if (n == 0)
					await_result('0, 0, STAT_EMPTY, 1'b1);
				else
					for (int i = 0; i < n; i++)
						await_result(held_values[i], n, STAT_OK, i == n - 1);
				return;
			end
			default: ;
		endcase
		await_result('0, held_values.size(), st, 1'b1);
	endfunction

	function automatic void compare_field(string field, longint due_val, longint seen_val);
		if (due_val != seen_val) begin
			$error("%s mismatch: expected %0d, got %0d", field, due_val, seen_val);
			mismatches++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		list_result_t due;
		if (!arst_n) begin
			held_values.delete();
			awaited_results.delete();
		end else begin
			if (req.valid && req.ready)
				apply_request(req.op, req.value, req.position);
			if (rsp.valid && rsp.ready) begin
				if (awaited_results.size() == 0) begin
					$error("unexpected result: value_out %0d length %0d status %0d last %0b",
						rsp.value_out, rsp.length, rsp.status, rsp.last);
					mismatches++;
				end else begin
					due = awaited_results.pop_front();
					compare_field("value_out", due.value_out, rsp.value_out);
					compare_field("length", due.length, rsp.length);
					compare_field("status", due.status, rsp.status);
					compare_field("last", due.last, rsp.last);
				end
			end
		end
		results_due <= awaited_results.size();
		fail_count  <= mismatches;
	end

endmodule

FILE: tb/sv/tb_top.sv
// Top of the positional list engine testbench: clock, reset, request stimulus,
// result consumer and verdict.
// Depends on ple_pkg, ple_if, positional_list_engine and ple_list_checker.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import ple_pkg::*;

	// op code seven has no meaning: the engine must answer it with a plain ok
	localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;
	localparam int RANDOM_ITEMS = 370;
	localparam int LONG_HOLD    = 400;
	localparam int HOLD_AFTER   = 80;

	logic clk = 1'b0;
	logic arst_n;
	int   fail_count;
	int   results_due;
	bit   sender_calm;

	ple_req_if req ();
	ple_rsp_if rsp ();

	positional_list_engine DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	ple_list_checker list_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req),
		.rsp         (rsp),
		.fail_count  (fail_count),
		.results_due (results_due)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Gap lengths: drawn from three ranges, the shortest most often and the longest least often.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(1, 3);
		if (r < 95)
			return $urandom_range(4, 8);
		return $urandom_range(20, 40);
	endfunction

	// Offer one item and hold it until the engine takes it. The caller's edge is
	// the one at which the previous item went in, so valid gets one assignment there.
	task automatic send_request(input logic [OP_W-1:0] code,
		input logic signed [VAL_W-1:0] val, input logic [POS_W-1:0] pos);
		int gap;
		gap = (!sender_calm && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
		if (gap > 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req.valid    <= 1'b1;
		req.op       <= code;
		req.value    <= val;
		req.position <= pos;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
	endtask

	// Stimulus: directed corner items, a fill to the brim, then random phases.
	initial begin
		int                      random_sent;
		int                      phase;
		int                      phase_len;
		int                      insert_share;
		int                      r;
		int                      sub;
		logic [OP_W-1:0]         code;
		logic signed [VAL_W-1:0] val;
		logic [POS_W-1:0]        pos;

		req.valid    <= 1'b0;
		req.op       <= OP_INS_FIRST;
		req.value    <= '0;
		req.position <= '0;
		sender_calm  = 1'b1;
		arst_n       = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty list: dump and every kind of delete, whatever the position
		send_request(OP_DUMP, 32'sd0, 7'd0);
		send_request(OP_DEL_FIRST, 32'sd0, 7'd0);
		send_request(OP_DEL_LAST, 32'sd0, 7'd0);
		send_request(OP_DEL_AT, 32'sd0, 7'd0);
		send_request(OP_DEL_AT, 32'sd0, 7'd127);
		// positioned insert into an empty list, then delete the only element
		send_request(OP_INS_AT, 32'sh7FFF_FFFF, 7'd1);
		send_request(OP_DEL_AT, 32'sd0, 7'd1);
		send_request(OP_INS_AT, 32'sd5, 7'd2);
		// build a short list from the value extremes
		send_request(OP_INS_FIRST, 32'sh8000_0000, 7'd0);
		send_request(OP_INS_LAST, 32'sh7FFF_FFFF, 7'd0);
		send_request(OP_INS_AT, 32'sd1, 7'd0);
		send_request(OP_INS_AT, 32'sd2, 7'd4);
		send_request(OP_INS_AT, -32'sd1, 7'd3);
		send_request(OP_INS_AT, 32'sd0, 7'd2);
		// bad delete positions: zero, one past the end, far past the end
		send_request(OP_DEL_AT, 32'sd0, 7'd0);
		send_request(OP_DEL_AT, 32'sd0, 7'd5);
		send_request(OP_DEL_AT, 32'sd0, 7'd127);
		send_request(OP_DUMP, 32'sd0, 7'd0);
		send_request(OP_UNUSED, -32'sd1, 7'd127);
		send_request(OP_DEL_AT, 32'sd0, 7'd4);
		send_request(OP_DEL_FIRST, 32'sd0, 7'd0);
		send_request(OP_DEL_LAST, 32'sd0, 7'd0);
		send_request(OP_DEL_LAST, 32'sd0, 7'd0);
		send_request(OP_DUMP, 32'sd0, 7'd0);

		// Fill to the brim and push past it: every insert kind must be refused
		// when full. The long dump afterwards is where the consumer's hold lands.
		sender_calm = 1'b0;
		for (int i = 0; i < DEPTH + 2; i++)
			send_request(OP_INS_LAST, $urandom(), 7'($urandom_range(0, 127)));
		send_request(OP_INS_FIRST, $urandom(), 7'd0);
		send_request(OP_INS_AT, $urandom(), 7'd1);
		send_request(OP_DUMP, 32'sd0, 7'd0);
		random_sent = DEPTH + 5;

		// Random phases: filling, draining and balanced, so the list keeps
		// swinging between empty and full. Positions favour the valid range.
		phase = 0;
		while (random_sent < RANDOM_ITEMS) begin
			phase_len   = $urandom_range(30, 50);
			sender_calm = ($urandom_range(0, 3) == 0);
			case (phase % 3)
				0: insert_share = 70;
				1: insert_share = 20;
				default: insert_share = 45;
			endcase
			for (int k = 0; k < phase_len && random_sent < RANDOM_ITEMS; k++) begin
				r   = $urandom_range(0, 99);
				sub = $urandom_range(0, 2);
				if (r < 7)
					code = OP_DUMP;
				else if (r < 8)
					code = OP_UNUSED;
				else if (r < 8 + insert_share)
					code = (sub == 0) ? OP_INS_FIRST : (sub == 1) ? OP_INS_LAST : OP_INS_AT;
				else
					code = (sub == 0) ? OP_DEL_FIRST : (sub == 1) ? OP_DEL_LAST : OP_DEL_AT;

				r = $urandom_range(0, 99);
				if (r < 10)
					pos = '0;
				else if (r < 75)
					pos = 7'($urandom_range(1, DEPTH + 1));
				else
					pos = 7'($urandom_range(0, 127));

				r   = $urandom_range(0, 19);
				val = (r == 0) ? 32'sh8000_0000 : (r == 1) ? 32'sh7FFF_FFFF : $urandom();

				send_request(code, val, pos);
				random_sent++;
			end
			phase++;
		end
		req.valid <= 1'b0;

		// Drain: wait for every awaited result, then give the engine time to
		// show anything extra it might still produce.
		@(posedge clk);
		while (results_due != 0) @(posedge clk);
		repeat (48) @(posedge clk);

		if (fail_count == 0 && results_due == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	// Result consumer: random stalls with calm stretches, and one long hold-off
	// so that the engine backs up and closes its request side.
	initial begin
		int results_taken;
		int stall_left;
		bit receiver_calm;
		bit long_hold_done;

		results_taken  = 0;
		stall_left     = 0;
		receiver_calm  = 1'b0;
		long_hold_done = 1'b0;
		rsp.ready <= 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			@(posedge clk);
			if (rsp.valid && rsp.ready)
				results_taken++;
			if (!long_hold_done && results_taken >= HOLD_AFTER) begin
				// hold off while the sender keeps offering items
				long_hold_done = 1'b1;
				rsp.ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				rsp.ready <= 1'b1;
			end else begin
				if ($urandom_range(0, 249) == 0)
					receiver_calm = !receiver_calm;
				if (stall_left > 0) begin
					stall_left--;
					rsp.ready <= 1'b0;
				end else begin
					rsp.ready <= 1'b1;
					if (!receiver_calm && $urandom_range(0, 3) == 0)
						stall_left = pick_gap();
				end
			end
		end
	end

	// Watchdog: well beyond the slowest correct run.
	initial begin
		#36ms;
		$display("Simulation FAILED");
		$finish;
	end

endmodule

FILE: filelist.f
design/ple_pkg.sv
design/ple_if.sv
design/ple_ram.sv
design/positional_list_engine.sv
design/ple_checker.sv
tb/sv/ple_list_checker.sv
tb/sv/tb_top.sv
